@@ rtl/assert_macros.svh @@
// assertion macros for the rtl of the spotlight luminance block, used by the top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsl same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define RSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsl next-cycle check failed");

`endif

@@ rtl/rsl_pkg.sv @@
// shared types, constants and the square root step for the spotlight luminance block
// no dependencies
`default_nettype none

package rsl_pkg;

  // luminance and scale factor
  localparam int LUMA_W      = 17;
  localparam int FACT_W      = 16;
  localparam logic [FACT_W-1:0] DIST_CLAMP = 16'd40960;  // 160.0 in q8.8
  localparam logic [FACT_W-1:0] FULL_SCALE = 16'd51200;  // 200.0 in q8.8
  localparam int CLAMP_SQ    = 25600;                    // 160 squared

  // square root datapath
  localparam int RAD_LOW_W   = 15;   // sum bits that reach the root when not clamped
  localparam int RAD_FRAC    = 16;   // radicand is sum times 65536
  localparam int RAD_W       = 32;
  localparam int ROOT_W      = 16;
  localparam int REM_W       = 17;
  localparam int CUR_W       = 19;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = 4;    // result bits per stage

  // division by 51200 = 2^11 * 25, the 25 by reciprocal
  localparam int PROD_W      = LUMA_W + FACT_W;
  localparam int DIV_SHIFT   = 11;
  localparam int QX_W        = PROD_W - DIV_SHIFT;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP = 23'd5368710;  // ceil(2^27 / 25)
  localparam int RECIP_SHIFT = 27;
  localparam int RPROD_W     = QX_W + RECIP_W;

  // pipeline stage positions
  localparam int STG_ABS     = 0;
  localparam int STG_SQR     = 1;
  localparam int STG_SUM     = 2;
  localparam int STG_SQRT0   = 3;
  localparam int STG_MUL     = STG_SQRT0 + SQRT_STAGES;
  localparam int STG_RECIP   = STG_MUL + 1;
  localparam int STG_OUT     = STG_RECIP + 1;
  localparam int PIPE_DEPTH  = STG_OUT + 1;

  // configuration register indexes
  localparam int CFG_IDX_W   = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_COL = 2'd0,
    REG_CENTER_ROW = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              clamp;
  } side_t;

  // one restoring digit step: bring in two radicand bits, decide one root bit
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    sqrt_acc_t         r;
    logic [CUR_W-1:0]  cur;
    logic [CUR_W-1:0]  trial;
    cur   = {a.rem, pair};
    trial = {1'b0, a.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[REM_W-1:0];
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rsl_pix_if.sv @@
// pixel input channel: valid/ready with column, row and luminance
// depends on rsl_pkg
`default_nettype none

interface rsl_pix_if #(parameter int COORD_BITS = 12);
  logic                           valid;
  logic                           ready;
  logic [COORD_BITS-1:0]          pixel_col;
  logic [COORD_BITS-1:0]          pixel_row;
  logic [rsl_pkg::LUMA_W-1:0]     luma_in;

  modport source (output valid, output pixel_col, output pixel_row, output luma_in,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input luma_in,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rsl_luma_if.sv @@
// result channel: valid/ready with dimmed luminance
// depends on rsl_pkg
`default_nettype none

interface rsl_luma_if;
  logic                       valid;
  logic                       ready;
  logic [rsl_pkg::LUMA_W-1:0] luma_out;

  modport source (output valid, output luma_out, input ready);
  modport sink   (input valid, input luma_out, output ready);
endinterface

`default_nettype wire

@@ rtl/rsl_cfg_if.sv @@
// configuration write channel: valid/ready with register index and write data
// depends on rsl_pkg
`default_nettype none

interface rsl_cfg_if #(parameter int COORD_BITS = 12);
  logic                          valid;
  logic                          ready;
  logic [rsl_pkg::CFG_IDX_W-1:0] idx;
  logic [COORD_BITS:0]           wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/rsl_dist.sv @@
// distance front end: absolute offsets, squares, sum with clamp test and radicand
// depends on rsl_pkg
`default_nettype none

module rsl_dist #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic [2:0]                     en,
  input  wire logic [COORD_BITS-1:0]          pixel_col,
  input  wire logic [COORD_BITS-1:0]          pixel_row,
  input  wire logic [rsl_pkg::LUMA_W-1:0]     luma_in,
  input  wire logic signed [COORD_BITS:0]     center_col,
  input  wire logic signed [COORD_BITS:0]     center_row,
  output rsl_pkg::side_t                      side_r,
  output logic [rsl_pkg::RAD_W-1:0]           rad_r
);

  localparam int ABS_W  = COORD_BITS + 1;
  localparam int DIFF_W = COORD_BITS + 2;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int SUM_CW = (SUM_W > rsl_pkg::RAD_LOW_W) ? SUM_W : rsl_pkg::RAD_LOW_W;

  logic signed [DIFF_W-1:0]    dx, dy;
  logic [DIFF_W-1:0]           ndx, ndy;
  logic [ABS_W-1:0]            adx_nxt, ady_nxt;
  logic [ABS_W-1:0]            adx_r, ady_r;
  logic [rsl_pkg::LUMA_W-1:0]  luma1_r, luma2_r;
  logic [SQ_W-1:0]             sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0]             sqx_r, sqy_r;
  logic [SUM_CW-1:0]           sum;
  rsl_pkg::side_t              side_nxt;
  logic [rsl_pkg::RAD_W-1:0]   rad_nxt;

  // signed offsets to the center, then magnitude
  always_comb begin
    dx      = $signed({2'b00, pixel_col}) - $signed({center_col[COORD_BITS], center_col});
    dy      = $signed({2'b00, pixel_row}) - $signed({center_row[COORD_BITS], center_row});
    ndx     = -dx;
    ndy     = -dy;
    adx_nxt = dx[DIFF_W-1] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
    ady_nxt = dy[DIFF_W-1] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
  end

  always_comb begin
    sqx_nxt = SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_nxt = SQ_W'(ady_r) * SQ_W'(ady_r);
  end

  always_comb begin
    sum            = SUM_CW'(sqx_r) + SUM_CW'(sqy_r);
    side_nxt.luma  = luma2_r;
    side_nxt.clamp = (sum >= SUM_CW'(rsl_pkg::CLAMP_SQ));
    rad_nxt        = {1'b0, sum[rsl_pkg::RAD_LOW_W-1:0], {rsl_pkg::RAD_FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      adx_r   <= adx_nxt;
      ady_r   <= ady_nxt;
      luma1_r <= luma_in;
    end
    if (en[1]) begin
      sqx_r   <= sqx_nxt;
      sqy_r   <= sqy_nxt;
      luma2_r <= luma1_r;
    end
    if (en[2]) begin
      side_r  <= side_nxt;
      rad_r   <= rad_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsl_sqrt_stage.sv @@
// one square root pipeline stage: four digit steps of the restoring root
// depends on rsl_pkg
`default_nettype none

module rsl_sqrt_stage (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire rsl_pkg::sqrt_acc_t         acc_i,
  input  wire logic [rsl_pkg::RAD_W-1:0]  rad_i,
  input  wire rsl_pkg::side_t             side_i,
  output rsl_pkg::sqrt_acc_t              acc_r,
  output logic [rsl_pkg::RAD_W-1:0]       rad_r,
  output rsl_pkg::side_t                  side_r
);

  rsl_pkg::sqrt_acc_t         acc_nxt;
  logic [rsl_pkg::RAD_W-1:0]  rad_nxt;

  // radicand shifts left two bits per step, top pair feeds the step
  always_comb begin
    acc_nxt = acc_i;
    rad_nxt = rad_i;
    for (int k = 0; k < rsl_pkg::SQRT_STEPS; k++) begin
      acc_nxt = rsl_pkg::sqrt_step(acc_nxt, rad_nxt[rsl_pkg::RAD_W-1 -: 2]);
      rad_nxt = {rad_nxt[rsl_pkg::RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= acc_nxt;
      rad_r  <= rad_nxt;
      side_r <= side_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsl_scale.sv @@
// back end: scale factor, luminance product, division by 51200, output register
// depends on rsl_pkg
`default_nettype none

module rsl_scale (
  input  wire logic                        clk,
  input  wire logic [2:0]                  en,
  input  wire logic [rsl_pkg::ROOT_W-1:0]  root,
  input  wire rsl_pkg::side_t              side_i,
  output logic [rsl_pkg::LUMA_W-1:0]       luma_out_r
);

  logic [rsl_pkg::FACT_W-1:0]  dq;
  logic [rsl_pkg::FACT_W-1:0]  factor;
  logic [rsl_pkg::PROD_W-1:0]  prod_nxt, prod_r;
  logic [rsl_pkg::QX_W-1:0]    qx;
  logic [rsl_pkg::RPROD_W-1:0] rprod_nxt, rprod_r;

  always_comb begin
    dq       = side_i.clamp ? rsl_pkg::DIST_CLAMP : root;
    factor   = rsl_pkg::FULL_SCALE - dq;
    prod_nxt = rsl_pkg::PROD_W'(side_i.luma) * rsl_pkg::PROD_W'(factor);
  end

  // floor(p / 51200) = floor(floor(p / 2048) / 25), the last by reciprocal
  always_comb begin
    qx        = prod_r[rsl_pkg::PROD_W-1:rsl_pkg::DIV_SHIFT];
    rprod_nxt = rsl_pkg::RPROD_W'(qx) * rsl_pkg::RPROD_W'(rsl_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
    end
    if (en[1]) begin
      rprod_r <= rprod_nxt;
    end
    if (en[2]) begin
      luma_out_r <= rprod_r[rsl_pkg::RECIP_SHIFT +: rsl_pkg::LUMA_W];
    end
  end

endmodule

`default_nettype wire

@@ rtl/radial_spotlight_luminance_unit.sv @@
// radial spotlight luminance unit, top level
// depends on rsl_pkg, the channel interfaces, rsl_dist, rsl_sqrt_stage, rsl_scale
//
// usage
// - in_pix (sink): one transaction per pixel with pixel_col, pixel_row and luma_in
//   (q1.16, 65536 = 1.0); out_luma (source): one luma_out transaction per pixel,
//   in the same order
// - cfg_wr (sink): idx 0 writes center_col, idx 1 writes center_row, both signed;
//   other indexes are dropped; ready is always high; write only while idle
// - pipeline: ten register stages (3 distance, 4 root, product, reciprocal, output);
//   each accepted pixel passes through them in that order to luma_out
// - throughput: one pixel per clock unless stalled; the square root is split over
//   four stages of four result bits each, so every stage holds a different pixel
// - stalls: each stage holds while its successor is full and blocked; bubbles
//   close up, so in_pix.ready stays high while any stage has room, even when
//   a finished result waits on out_luma.ready
// - reset (rst_n low, synchronous): all stage valid bits clear and both center
//   registers return to zero; the pipeline is empty and ready afterwards
`default_nettype none

`include "assert_macros.svh"

module radial_spotlight_luminance_unit #(
  parameter int COORD_BITS = 12
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rsl_pix_if.sink         in_pix,
  rsl_luma_if.source      out_luma,
  rsl_cfg_if.sink         cfg_wr
);

  localparam int NST = rsl_pkg::PIPE_DEPTH;

  // center registers
  logic signed [COORD_BITS:0]  center_col_r, center_col_nxt;
  logic signed [COORD_BITS:0]  center_row_r, center_row_nxt;

  // stage valid bits and advance enables
  logic [NST-1:0]              v_r, v_nxt;
  logic [NST-1:0]              en;

  // datapath between the parts
  rsl_pkg::side_t              dist_side;
  logic [rsl_pkg::RAD_W-1:0]   dist_rad;
  rsl_pkg::sqrt_acc_t          sq_acc  [rsl_pkg::SQRT_STAGES+1];
  logic [rsl_pkg::RAD_W-1:0]   sq_rad  [rsl_pkg::SQRT_STAGES+1];
  rsl_pkg::side_t              sq_side [rsl_pkg::SQRT_STAGES+1];
  logic [rsl_pkg::LUMA_W-1:0]  luma_out_r;

  // configuration writes; unknown indexes leave both registers alone
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    if (cfg_wr.valid && (cfg_wr.idx == rsl_pkg::REG_CENTER_COL)) begin
      center_col_nxt = cfg_wr.wdata;
    end else if (cfg_wr.valid && (cfg_wr.idx == rsl_pkg::REG_CENTER_ROW)) begin
      center_row_nxt = cfg_wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
    end else begin
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
    end
  end

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_luma.ready;
    for (int i = NST-2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_pix.valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_pix.ready = en[0];

  // offsets, squares, sum and clamp test
  rsl_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk        (clk),
    .en         (en[rsl_pkg::STG_SUM:rsl_pkg::STG_ABS]),
    .pixel_col  (in_pix.pixel_col),
    .pixel_row  (in_pix.pixel_row),
    .luma_in    (in_pix.luma_in),
    .center_col (center_col_r),
    .center_row (center_row_r),
    .side_r     (dist_side),
    .rad_r      (dist_rad)
  );

  // pipelined square root, four result bits per stage
  assign sq_acc[0]  = '0;
  assign sq_rad[0]  = dist_rad;
  assign sq_side[0] = dist_side;

  for (genvar s = 0; s < rsl_pkg::SQRT_STAGES; s++) begin : g_sqrt
    rsl_sqrt_stage u_sqrt (
      .clk    (clk),
      .en     (en[rsl_pkg::STG_SQRT0 + s]),
      .acc_i  (sq_acc[s]),
      .rad_i  (sq_rad[s]),
      .side_i (sq_side[s]),
      .acc_r  (sq_acc[s+1]),
      .rad_r  (sq_rad[s+1]),
      .side_r (sq_side[s+1])
    );
  end

  // scale factor, product and division by 51200
  rsl_scale u_scale (
    .clk        (clk),
    .en         (en[rsl_pkg::STG_OUT:rsl_pkg::STG_MUL]),
    .root       (sq_acc[rsl_pkg::SQRT_STAGES].root),
    .side_i     (sq_side[rsl_pkg::SQRT_STAGES]),
    .luma_out_r (luma_out_r)
  );

  assign out_luma.valid    = v_r[NST-1];
  assign out_luma.luma_out = luma_out_r;

  // with nothing waiting at the output, every stage can move
  `RSL_ASSERT_SAME(a_ready_when_out_empty, !out_luma.valid, in_pix.ready)
  // an accepted transaction lands in the first stage
  `RSL_ASSERT_NEXT(a_accept_fills_first, in_pix.valid && in_pix.ready, v_r[0])
  // a blocked first stage keeps its transaction
  `RSL_ASSERT_NEXT(a_blocked_stage_kept, v_r[0] && !en[1], v_r[0])
  // a column write lands in the center register
  `RSL_ASSERT_NEXT(a_cfg_col_written, cfg_wr.valid && (cfg_wr.idx == rsl_pkg::REG_CENTER_COL), center_col_r == $past(cfg_wr.wdata))

endmodule

`default_nettype wire
